>>> src/cylindrical_warp_map_generator_assert.svh
// Assertion macros for the cylindrical warp map generator.
// Every macro expects signals named clk and rst_n in the using module.
`ifndef CYLINDRICAL_WARP_MAP_GENERATOR_ASSERT_SVH
`define CYLINDRICAL_WARP_MAP_GENERATOR_ASSERT_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define CWM_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cwm: same-cycle check failed");
// next-cycle implication
`define CWM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cwm: next-cycle check failed");
`else
`define CWM_ASSERT_IMPLY(label, ante, cons)
`define CWM_ASSERT_NEXT(label, ante, cons)
`endif
`endif

>>> src/cwm_pkg.sv
`default_nettype none

package cwm_pkg;

    // default values of the top-level parameters
    localparam int MAX_DIM_DEF    = 4096;
    localparam int FRAC_BITS_DEF  = 5;
    localparam int ANGLE_ITER_DEF = 16;

    // fixed field widths
    localparam int COL_W      = 12;
    localparam int DIM_W      = 13;
    localparam int FOCAL_W    = 16;
    localparam int OUT_W      = 17;
    localparam int IDX_W      = 2;
    localparam int CFG_DATA_W = 16;

    // register indexes
    localparam logic [IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
    localparam logic [IDX_W-1:0] REG_FOCAL_LENGTH = 2'd2;

    // register reset values
    localparam logic [DIM_W-1:0]   WIDTH_RST  = 13'd640;
    localparam logic [DIM_W-1:0]   HEIGHT_RST = 13'd480;
    localparam logic [FOCAL_W-1:0] FOCAL_RST  = 16'd720;

    // angle and rotation arithmetic
    localparam int ANG_FRAC     = 28;
    localparam int UNIT_SHIFT   = 30;
    localparam int ZQ_BITS      = 29;
    localparam int THETA_LIMIT  = 402653184;
    localparam int GAIN_INV_Q30 = 652032874;
    localparam int X_W          = 34;
    localparam int Z_W          = 31;
    localparam int ATAN_LEN     = 24;

    // atan(2^-i) in Q28
    localparam int ATAN_Q28 [ATAN_LEN] = '{
        210828714, 124459457, 65760959, 33381290, 16755422, 8385879,
        4193963, 2097109, 1048571, 524287, 262144, 131072,
        65536, 32768, 16384, 8192, 4096, 2048,
        1024, 512, 256, 128, 64, 32
    };

    // side data that rides along the angle and rotation stages
    typedef struct packed {
        logic                    ok;
        logic                    cx_neg;
        logic signed [DIM_W-1:0] cy;
    } cwm_tag_t;

endpackage

`default_nettype wire

>>> src/cylindrical_warp_map_generator.sv
`default_nettype none
`include "cylindrical_warp_map_generator_assert.svh"

// Cylindrical warp map generator: for each destination pixel request
// (dest_col, dest_row) it returns the source position src_x, src_y in
// unsigned fixed point with FRAC_BITS fraction bits, and in_range = 1 when
// that source lies inside the image (else all zero). One request is taken
// every clock cycle while dest_stall is low; each request passes through the
// angle divider, the CORDIC stages, the multiplier, the output dividers and
// the output register. A one-entry skid register behind the output takes
// the request that leaves the pipeline while src_stall is high; the
// pipeline and dest_stall hold while it is occupied.
// Image width, height and focal length are written through cfg_we; the user
// must write them only while the block is empty, which the block does not enforce.
module cylindrical_warp_map_generator
    import cwm_pkg::*;
#(
    parameter int MAX_DIM          = MAX_DIM_DEF,
    parameter int FRAC_BITS        = FRAC_BITS_DEF,
    parameter int ANGLE_ITERATIONS = ANGLE_ITER_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [IDX_W-1:0]      cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  dest_valid,
    output logic                       dest_stall,
    input  wire logic [COL_W-1:0]      dest_col,
    input  wire logic [COL_W-1:0]      dest_row,
    output logic                       src_valid,
    input  wire logic                  src_stall,
    output logic [OUT_W-1:0]           src_x,
    output logic [OUT_W-1:0]           src_y,
    output logic                       in_range
);

    localparam int TAG_W  = $bits(cwm_tag_t);
    localparam int TH_W   = COL_W + ANG_FRAC;
    localparam int PROD_W = FOCAL_W + X_W - 1;
    localparam int NX_W   = PROD_W + FRAC_BITS + 1;
    localparam int NY_W   = COL_W + UNIT_SHIFT + FRAC_BITS + 1;
    localparam int QB_OUT = $clog2(MAX_DIM) + FRAC_BITS + 1;
    localparam int SUM_W  = DIM_W + FRAC_BITS + 2;
    localparam int DEN_W  = X_W - 1;

    // configuration registers
    logic [DIM_W-1:0]   width_reg;
    logic [DIM_W-1:0]   height_reg;
    logic [FOCAL_W-1:0] focal_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RST;
            height_reg <= HEIGHT_RST;
            focal_reg  <= FOCAL_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_IMAGE_WIDTH:  width_reg  <= cfg_data[DIM_W-1:0];
                REG_IMAGE_HEIGHT: height_reg <= cfg_data[DIM_W-1:0];
                REG_FOCAL_LENGTH: focal_reg  <= cfg_data;
                default:          ;
            endcase
        end
    end

    // pipeline enable: frozen only while the skid register is occupied
    logic ce;
    logic skid_valid_reg;

    assign ce         = !skid_valid_reg;
    assign dest_stall = skid_valid_reg;

    // entry: config check, loop area, centered offsets
    logic                    cfg_ok;
    logic                    in_loop;
    logic [COL_W-1:0]        half_w;
    logic [COL_W-1:0]        half_h;
    logic signed [DIM_W-1:0] cx;
    logic signed [DIM_W-1:0] cx_abs;
    logic [COL_W-1:0]        cx_mag;
    cwm_tag_t                entry_tag;

    assign cfg_ok = (width_reg >= DIM_W'(2)) && (32'(width_reg) <= MAX_DIM) &&
                    (height_reg >= DIM_W'(2)) && (32'(height_reg) <= MAX_DIM) &&
                    (focal_reg != '0);
    assign half_w  = width_reg[DIM_W-1:1];
    assign half_h  = height_reg[DIM_W-1:1];
    assign in_loop = ({1'b0, dest_col} < {half_w, 1'b0}) &&
                     ({1'b0, dest_row} < {half_h, 1'b0});
    assign cx      = signed'({1'b0, dest_col}) - signed'({1'b0, half_w});
    assign cx_abs  = cx[DIM_W-1] ? -cx : cx;
    assign cx_mag  = cx_abs[COL_W-1:0];

    always_comb
    begin
        entry_tag.ok     = cfg_ok && in_loop;
        entry_tag.cx_neg = cx[DIM_W-1];
        entry_tag.cy     = signed'({1'b0, dest_row}) - signed'({1'b0, half_h});
    end

    // angle magnitude |cx| * 2^28 / f
    logic                    th_valid;
    logic signed [ZQ_BITS:0] th_quo;
    logic                    th_ovf;
    logic [TAG_W-1:0]        th_tag_bits;

    cwm_div #(
        .NUM_W (TH_W),
        .DEN_W (FOCAL_W),
        .QB    (ZQ_BITS),
        .TAG_W (TAG_W)
    ) u_theta_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .ce        (ce),
        .in_valid  (dest_valid && !dest_stall),
        .num_mag   ({cx_mag, ANG_FRAC'(0)}),
        .num_neg   (1'b0),
        .den       (focal_reg),
        .in_tag    (entry_tag),
        .out_valid (th_valid),
        .quo       (th_quo),
        .ovf       (th_ovf),
        .out_tag   (th_tag_bits)
    );

    // angle limit near pi/2
    cwm_tag_t th_tag;
    cwm_tag_t rot_tag;

    always_comb
    begin
        th_tag     = cwm_tag_t'(th_tag_bits);
        rot_tag    = th_tag;
        rot_tag.ok = th_tag.ok && !th_ovf && (th_quo < (ZQ_BITS+1)'(THETA_LIMIT));
    end

    logic                  cr_valid;
    logic signed [X_W-1:0] cr_x;
    logic signed [X_W-1:0] cr_y;
    logic [TAG_W-1:0]      cr_tag_bits;

    cwm_cordic #(
        .ITERS (ANGLE_ITERATIONS),
        .TAG_W (TAG_W)
    ) u_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .ce        (ce),
        .in_valid  (th_valid),
        .z_in      (Z_W'(th_quo)),
        .in_tag    (rot_tag),
        .out_valid (cr_valid),
        .x_out     (cr_x),
        .y_out     (cr_y),
        .out_tag   (cr_tag_bits)
    );

    // multiplier stage: f * |sin|
    cwm_tag_t              cr_tag;
    logic signed [X_W-1:0] y_abs;
    logic                  x_pos;
    logic                  mul_valid_reg;
    logic [PROD_W-1:0]     prod_reg;
    logic                  negx_reg;
    logic [DEN_W-1:0]      den_reg;
    cwm_tag_t              mtag_reg;

    assign cr_tag = cwm_tag_t'(cr_tag_bits);
    assign y_abs  = cr_y[X_W-1] ? -cr_y : cr_y;
    assign x_pos  = !cr_x[X_W-1] && (cr_x != '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mul_valid_reg <= 1'b0;
        else if (ce)
            mul_valid_reg <= cr_valid;
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            prod_reg <= PROD_W'(PROD_W'(focal_reg) * PROD_W'(y_abs[X_W-2:0]));
            negx_reg <= cr_y[X_W-1] ^ cr_tag.cx_neg;
            den_reg  <= cr_x[DEN_W-1:0];
            mtag_reg <= '{ok: cr_tag.ok && x_pos, cx_neg: cr_tag.cx_neg, cy: cr_tag.cy};
        end
    end

    // output dividers by the cosine
    logic signed [DIM_W-1:0]  cy_abs;
    logic [COL_W-1:0]         cy_mag;
    logic                     divx_valid;
    logic                     divy_valid;
    logic signed [QB_OUT:0]   qx;
    logic signed [QB_OUT:0]   qy;
    logic                     ovfx;
    logic                     ovfy;
    logic [0:0]               okx;
    logic [0:0]               oky;

    assign cy_abs = mtag_reg.cy[DIM_W-1] ? -mtag_reg.cy : mtag_reg.cy;
    assign cy_mag = cy_abs[COL_W-1:0];

    cwm_div #(
        .NUM_W (NX_W),
        .DEN_W (DEN_W),
        .QB    (QB_OUT),
        .TAG_W (1)
    ) u_div_x (
        .clk       (clk),
        .rst_n     (rst_n),
        .ce        (ce),
        .in_valid  (mul_valid_reg),
        .num_mag   ({prod_reg, {(FRAC_BITS+1){1'b0}}}),
        .num_neg   (negx_reg),
        .den       (den_reg),
        .in_tag    (mtag_reg.ok),
        .out_valid (divx_valid),
        .quo       (qx),
        .ovf       (ovfx),
        .out_tag   (okx)
    );

    cwm_div #(
        .NUM_W (NY_W),
        .DEN_W (DEN_W),
        .QB    (QB_OUT),
        .TAG_W (1)
    ) u_div_y (
        .clk       (clk),
        .rst_n     (rst_n),
        .ce        (ce),
        .in_valid  (mul_valid_reg),
        .num_mag   ({cy_mag, {(UNIT_SHIFT+FRAC_BITS+1){1'b0}}}),
        .num_neg   (mtag_reg.cy[DIM_W-1]),
        .den       (den_reg),
        .in_tag    (mtag_reg.ok),
        .out_valid (divy_valid),
        .quo       (qy),
        .ovf       (ovfy),
        .out_tag   (oky)
    );

    // recenter and range check
    logic signed [SUM_W-1:0] half_wf;
    logic signed [SUM_W-1:0] full_wf;
    logic signed [SUM_W-1:0] half_hf;
    logic signed [SUM_W-1:0] full_hf;
    logic signed [SUM_W-1:0] sx2;
    logic signed [SUM_W-1:0] sy2;
    logic [SUM_W-1:0]        sx2_u;
    logic [SUM_W-1:0]        sy2_u;
    logic                    res_ok;
    logic [OUT_W-1:0]        res_x;
    logic [OUT_W-1:0]        res_y;

    assign half_wf = SUM_W'(width_reg) << FRAC_BITS;
    assign full_wf = SUM_W'(width_reg) << (FRAC_BITS + 1);
    assign half_hf = SUM_W'(height_reg) << FRAC_BITS;
    assign full_hf = SUM_W'(height_reg) << (FRAC_BITS + 1);
    assign sx2     = half_wf + SUM_W'(qx);
    assign sy2     = half_hf + SUM_W'(qy);
    assign sx2_u   = sx2;
    assign sy2_u   = sy2;
    assign res_ok  = okx[0] && oky[0] && !ovfx && !ovfy &&
                     (sx2 >= 0) && (sx2 < full_wf) && (sy2 >= 0) && (sy2 < full_hf);
    assign res_x   = res_ok ? OUT_W'(sx2_u >> 1) : '0;
    assign res_y   = res_ok ? OUT_W'(sy2_u >> 1) : '0;

    // output register with skid register behind it
    logic             out_valid_reg;
    logic [OUT_W-1:0] src_x_reg;
    logic [OUT_W-1:0] src_y_reg;
    logic             in_range_reg;
    logic [OUT_W-1:0] skid_x_reg;
    logic [OUT_W-1:0] skid_y_reg;
    logic             skid_ok_reg;
    logic             out_free;
    logic             deliver;

    assign out_free = !out_valid_reg || !src_stall;
    assign deliver  = divx_valid && ce;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg  <= skid_valid_reg || deliver;
            skid_valid_reg <= 1'b0;
        end
        else if (deliver)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            src_x_reg    <= skid_valid_reg ? skid_x_reg : res_x;
            src_y_reg    <= skid_valid_reg ? skid_y_reg : res_y;
            in_range_reg <= skid_valid_reg ? skid_ok_reg : res_ok;
        end
        else if (deliver)
        begin
            skid_x_reg  <= res_x;
            skid_y_reg  <= res_y;
            skid_ok_reg <= res_ok;
        end
    end

    assign src_valid = out_valid_reg;
    assign src_x     = src_x_reg;
    assign src_y     = src_y_reg;
    assign in_range  = in_range_reg;

    `CWM_ASSERT_IMPLY(a_skid_needs_out, skid_valid_reg, out_valid_reg)
    `CWM_ASSERT_IMPLY(a_div_lockstep, 1'b1, divx_valid == divy_valid)
    `CWM_ASSERT_IMPLY(a_miss_is_zero, out_valid_reg && !in_range_reg, src_x_reg == '0 && src_y_reg == '0)
    `CWM_ASSERT_NEXT(a_held_fills_skid, out_valid_reg && src_stall && !skid_valid_reg && divx_valid, skid_valid_reg)

endmodule

`default_nettype wire

>>> src/cwm_div.sv
`default_nettype none

// Pipelined restoring divider, one quotient bit per stage, floor rounding
// for a signed numerator given as sign and magnitude. Quotients that need
// more than QB bits are flagged as overflow.
module cwm_div
#(
    parameter int NUM_W = 40,
    parameter int DEN_W = 16,
    parameter int QB    = 29,
    parameter int TAG_W = 1
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                ce,
    input  wire logic                in_valid,
    input  wire logic [NUM_W-1:0]    num_mag,
    input  wire logic                num_neg,
    input  wire logic [DEN_W-1:0]    den,
    input  wire logic [TAG_W-1:0]    in_tag,
    output logic                     out_valid,
    output logic signed [QB:0]       quo,
    output logic                     ovf,
    output logic [TAG_W-1:0]         out_tag
);

    logic             v_reg   [QB+1];
    logic [DEN_W-1:0] rem_reg [QB+1];
    logic [QB-1:0]    low_reg [QB+1];
    logic [QB-1:0]    quo_reg [QB+1];
    logic [DEN_W-1:0] den_reg [QB+1];
    logic             neg_reg [QB+1];
    logic             ovf_reg [QB+1];
    logic [TAG_W-1:0] tag_reg [QB+1];

    logic [NUM_W-1:0] hi_part;
    logic [NUM_W-1:0] den_ext;
    logic             ovf_next;

    // entry: upper numerator part must stay below the divisor
    assign hi_part  = num_mag >> QB;
    assign den_ext  = NUM_W'(den);
    assign ovf_next = (hi_part >= den_ext);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg[0] <= 1'b0;
        else if (ce)
            v_reg[0] <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            rem_reg[0] <= DEN_W'(hi_part);
            low_reg[0] <= num_mag[QB-1:0];
            quo_reg[0] <= '0;
            den_reg[0] <= den;
            neg_reg[0] <= num_neg;
            ovf_reg[0] <= ovf_next;
            tag_reg[0] <= in_tag;
        end
    end

    // one quotient bit per stage
    for (genvar k = 1; k <= QB; k++)
    begin : g_step
        logic [DEN_W:0] trial;
        logic           fits;

        assign trial = {rem_reg[k-1], low_reg[k-1][QB-1]};
        assign fits  = (trial >= {1'b0, den_reg[k-1]});

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[k] <= 1'b0;
            else if (ce)
                v_reg[k] <= v_reg[k-1];
        end

        always_ff @(posedge clk)
        begin
            if (ce)
            begin
                rem_reg[k] <= fits ? DEN_W'(trial - {1'b0, den_reg[k-1]}) : DEN_W'(trial);
                low_reg[k] <= low_reg[k-1] << 1;
                quo_reg[k] <= (quo_reg[k-1] << 1) | QB'(fits);
                den_reg[k] <= den_reg[k-1];
                neg_reg[k] <= neg_reg[k-1];
                ovf_reg[k] <= ovf_reg[k-1];
                tag_reg[k] <= tag_reg[k-1];
            end
        end
    end

    // floor correction for negative numerators
    logic [QB:0]        qext;
    logic               rem_nz;
    logic signed [QB:0] quo_next;
    logic               out_v_reg;
    logic signed [QB:0] quo_out_reg;
    logic               ovf_out_reg;
    logic [TAG_W-1:0]   tag_out_reg;

    assign qext   = {1'b0, quo_reg[QB]};
    assign rem_nz = |rem_reg[QB];

    always_comb
    begin
        if (neg_reg[QB])
            quo_next = rem_nz ? signed'(~qext) : signed'(-qext);
        else
            quo_next = signed'(qext);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_v_reg <= 1'b0;
        else if (ce)
            out_v_reg <= v_reg[QB];
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            quo_out_reg <= quo_next;
            ovf_out_reg <= ovf_reg[QB];
            tag_out_reg <= tag_reg[QB];
        end
    end

    assign out_valid = out_v_reg;
    assign quo       = quo_out_reg;
    assign ovf       = ovf_out_reg;
    assign out_tag   = tag_out_reg;

endmodule

`default_nettype wire

>>> src/cwm_cordic.sv
`default_nettype none

// Rotation-mode CORDIC, one iteration per register stage. Starts from the
// inverse gain on the x axis, so the result is (cos, sin) of z in Q30.
module cwm_cordic
    import cwm_pkg::*;
#(
    parameter int ITERS = ANGLE_ITER_DEF,
    parameter int TAG_W = 1
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  ce,
    input  wire logic                  in_valid,
    input  wire logic signed [Z_W-1:0] z_in,
    input  wire logic [TAG_W-1:0]      in_tag,
    output logic                       out_valid,
    output logic signed [X_W-1:0]      x_out,
    output logic signed [X_W-1:0]      y_out,
    output logic [TAG_W-1:0]           out_tag
);

    logic                  v_reg   [ITERS+1];
    logic signed [X_W-1:0] x_reg   [ITERS+1];
    logic signed [X_W-1:0] y_reg   [ITERS+1];
    logic signed [Z_W-1:0] z_reg   [ITERS+1];
    logic [TAG_W-1:0]      tag_reg [ITERS+1];

    // start vector
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg[0] <= 1'b0;
        else if (ce)
            v_reg[0] <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            x_reg[0]   <= X_W'(GAIN_INV_Q30);
            y_reg[0]   <= '0;
            z_reg[0]   <= z_in;
            tag_reg[0] <= in_tag;
        end
    end

    // micro-rotations
    for (genvar i = 0; i < ITERS; i++)
    begin : g_iter
        logic signed [X_W-1:0] xs;
        logic signed [X_W-1:0] ys;
        logic signed [Z_W-1:0] ang;
        logic                  up;

        assign xs  = x_reg[i] >>> i;
        assign ys  = y_reg[i] >>> i;
        assign ang = Z_W'(ATAN_Q28[i]);
        assign up  = !z_reg[i][Z_W-1];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[i+1] <= 1'b0;
            else if (ce)
                v_reg[i+1] <= v_reg[i];
        end

        always_ff @(posedge clk)
        begin
            if (ce)
            begin
                x_reg[i+1]   <= up ? x_reg[i] - ys : x_reg[i] + ys;
                y_reg[i+1]   <= up ? y_reg[i] + xs : y_reg[i] - xs;
                z_reg[i+1]   <= up ? z_reg[i] - ang : z_reg[i] + ang;
                tag_reg[i+1] <= tag_reg[i];
            end
        end
    end

    assign out_valid = v_reg[ITERS];
    assign x_out     = x_reg[ITERS];
    assign y_out     = y_reg[ITERS];
    assign out_tag   = tag_reg[ITERS];

endmodule

`default_nettype wire

>>> bench/cylindrical_warp_map_generator_tb.sv
`default_nettype none

module cylindrical_warp_map_generator_tb
    import cwm_pkg::*;
();

    localparam int MAX_DIM   = MAX_DIM_DEF;
    localparam int FRAC_BITS = FRAC_BITS_DEF;
    localparam int ITERS     = ANGLE_ITER_DEF;
    localparam int LATENCY   = 70;

    typedef struct packed {
        logic [COL_W-1:0] col;
        logic [COL_W-1:0] row;
    } pixel_t;

    typedef struct packed {
        logic [OUT_W-1:0] x;
        logic [OUT_W-1:0] y;
        logic             ok;
    } src_pos_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [IDX_W-1:0]      cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  dest_valid;
    logic                  dest_stall;
    logic [COL_W-1:0]      dest_col;
    logic [COL_W-1:0]      dest_row;
    logic                  src_valid;
    logic                  src_stall;
    logic [OUT_W-1:0]      src_x;
    logic [OUT_W-1:0]      src_y;
    logic                  in_range;

    // predictor copy of the registers
    logic [DIM_W-1:0]   img_w;
    logic [DIM_W-1:0]   img_h;
    logic [FOCAL_W-1:0] focal;

    pixel_t   pending_px[$];
    src_pos_t expected_pos[$];
    int       n_errors;
    int       burst_left;
    int       gap_left;
    int       stall_phase;
    bit       hold_sender;

    cylindrical_warp_map_generator u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .dest_valid(dest_valid),
        .dest_stall(dest_stall),
        .dest_col  (dest_col),
        .dest_row  (dest_row),
        .src_valid (src_valid),
        .src_stall (src_stall),
        .src_x     (src_x),
        .src_y     (src_y),
        .in_range  (in_range)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    function automatic longint fdiv(longint n, longint d);
        longint q;
        q = n / d;
        if ((n % d) != 0 && n < 0)
            q = q - 1;
        return q;
    endfunction

    // inverse cylindrical map of one pixel
    function automatic src_pos_t warp_source(pixel_t px);
        src_pos_t r;
        longint w, h, f, hw, hh, cx, cy, mag, z, x, y, xs, ys, a, s, sx2, sy2;
        r = '0;
        w = img_w;
        h = img_h;
        f = focal;
        if (w < 2 || w > MAX_DIM || h < 2 || h > MAX_DIM || f == 0)
            return r;
        hw = w >>> 1;
        hh = h >>> 1;
        if (px.col >= 2 * hw || px.row >= 2 * hh)
            return r;
        cx = longint'(px.col) - hw;
        cy = longint'(px.row) - hh;
        mag = cx < 0 ? -cx : cx;
        z = (mag <<< ANG_FRAC) / f;
        if (z >= THETA_LIMIT)
            return r;
        x = GAIN_INV_Q30;
        y = 0;
        for (int i = 0; i < ITERS && i < ATAN_LEN; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0)
            begin
                x = x - ys;
                y = y + xs;
                z = z - ATAN_Q28[i];
            end
            else
            begin
                x = x + ys;
                y = y - xs;
                z = z + ATAN_Q28[i];
            end
        end
        if (x <= 0)
            return r;
        a = f * y;
        if (cx < 0)
            a = -a;
        s = longint'(1) <<< (FRAC_BITS + 1);
        sx2 = w * (s / 2) + fdiv(a * s, x);
        sy2 = h * (s / 2) + fdiv(cy * (longint'(1) <<< UNIT_SHIFT) * s, x);
        if (sx2 < 0 || sx2 >= w * s || sy2 < 0 || sy2 >= h * s)
            return r;
        r.x = OUT_W'(sx2 >>> 1);
        r.y = OUT_W'(sy2 >>> 1);
        r.ok = 1'b1;
        return r;
    endfunction

    // request driver: bursts and gaps
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dest_valid <= 1'b0;
            dest_col   <= '0;
            dest_row   <= '0;
            burst_left <= 0;
            gap_left   <= 0;
        end
        else if (!(dest_valid && dest_stall))
        begin
            if (dest_valid)
                expected_pos = {expected_pos, warp_source(pixel_t'({dest_col, dest_row}))};
            if (gap_left > 0 || hold_sender || pending_px.size() == 0)
            begin
                dest_valid <= 1'b0;
                if (gap_left > 0)
                    gap_left <= gap_left - 1;
            end
            else
            begin
                pixel_t p;
                p = pending_px.pop_front();
                dest_valid <= 1'b1;
                dest_col   <= p.col;
                dest_row   <= p.row;
                if (burst_left == 0)
                begin
                    burst_left <= $urandom_range(0, 40);
                    gap_left   <= ($urandom_range(0, 2) == 0) ? $urandom_range(1, 6) : 0;
                end
                else
                    burst_left <= burst_left - 1;
            end
        end
    end

    // response stall pattern
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_stall   <= 1'b0;
            stall_phase <= 0;
        end
        else
        begin
            stall_phase <= stall_phase + 1;
            if (stall_phase[8])
                src_stall <= 1'b0;
            else if (stall_phase[6])
                src_stall <= ($urandom_range(0, 1) == 1);
            else
                src_stall <= ($urandom_range(0, 5) == 0);
        end
    end

    // response checker
    always @(posedge clk)
    begin
        if (rst_n && src_valid && !src_stall)
        begin
            if (expected_pos.size() == 0)
            begin
                $display("%0t: unexpected response x=%0d y=%0d ok=%0d",
                         $time, src_x, src_y, in_range);
                n_errors++;
            end
            else
            begin
                src_pos_t e;
                e = expected_pos.pop_front();
                if (src_x !== e.x)
                begin
                    $display("%0t: src_x expected %0d actual %0d", $time, e.x, src_x);
                    n_errors++;
                end
                if (src_y !== e.y)
                begin
                    $display("%0t: src_y expected %0d actual %0d", $time, e.y, src_y);
                    n_errors++;
                end
                if (in_range !== e.ok)
                begin
                    $display("%0t: in_range expected %0d actual %0d",
                             $time, e.ok, in_range);
                    n_errors++;
                end
            end
        end
    end

    task automatic wait_drained();
        while (pending_px.size() != 0 || dest_valid || expected_pos.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
    endtask

    // one register write; the caller drops cfg_we after the last one
    task automatic write_reg(logic [IDX_W-1:0] idx, int value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_W'(value);
        @(posedge clk);
        if (idx == REG_IMAGE_WIDTH)
            img_w = DIM_W'(value);
        else if (idx == REG_IMAGE_HEIGHT)
            img_h = DIM_W'(value);
        else if (idx == REG_FOCAL_LENGTH)
            focal = FOCAL_W'(value);
    endtask

    task automatic set_geometry(int w, int h, int f);
        write_reg(REG_IMAGE_WIDTH, w);
        write_reg(REG_IMAGE_HEIGHT, h);
        write_reg(REG_FOCAL_LENGTH, f);
        cfg_we <= 1'b0;
    endtask

    task automatic push_px(int c, int r);
        pixel_t p;
        p.col = COL_W'(c);
        p.row = COL_W'(r);
        pending_px = {pending_px, p};
    endtask

    // random pixels, mostly inside the loop area
    task automatic push_random(int n);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 9) == 0 || img_w < 2 || img_h < 2)
                push_px($urandom_range(0, 4095), $urandom_range(0, 4095));
            else
                push_px($urandom_range(0, img_w > 4096 ? 4095 : img_w - 1),
                        $urandom_range(0, img_h > 4096 ? 4095 : img_h - 1));
        end
    endtask

    initial
    begin
        n_errors    = 0;
        hold_sender = 0;
        img_w       = WIDTH_RST;
        img_h       = HEIGHT_RST;
        focal       = FOCAL_RST;
        rst_n       = 1'b0;
        cfg_we      = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset geometry, corners, center, outside loop area
        push_px(0, 0);
        push_px(639, 479);
        push_px(320, 240);
        push_px(4095, 4095);
        push_px(640, 0);
        push_px(0, 480);
        push_px(319, 0);
        push_px(321, 479);
        push_random(120);
        wait_drained();

        // short focal: angle limit, cosine near zero, source outside image
        set_geometry(640, 480, 100);
        push_px(0, 240);
        push_px(169, 240);
        push_px(170, 240);
        push_px(470, 240);
        push_px(639, 0);
        push_px(320, 0);
        push_random(150);
        wait_drained();

        // sender held back while requests queue up, then released
        hold_sender = 1;
        push_random(200);
        repeat (30) @(posedge clk);
        hold_sender = 0;
        wait_drained();

        // bad geometry, then extremes of width, height and focal
        set_geometry(1, 480, 720);
        push_px(0, 0);
        push_random(20);
        wait_drained();
        set_geometry(4097, 480, 720);
        push_random(20);
        wait_drained();
        set_geometry(640, 480, 0);
        push_random(20);
        wait_drained();
        set_geometry(4096, 4096, 65535);
        push_px(0, 0);
        push_px(4095, 4095);
        push_px(2048, 2048);
        push_random(250);
        wait_drained();
        set_geometry(2, 2, 1);
        push_px(0, 0);
        push_px(1, 1);
        push_px(2, 2);
        push_random(40);
        wait_drained();
        set_geometry(3, 5, 1);
        push_random(40);
        wait_drained();
        set_geometry(4096, 4096, 1000);
        push_random(250);
        wait_drained();
        set_geometry(8191, 8191, 65535);
        push_random(20);
        wait_drained();
        for (int k = 0; k < 4; k++)
        begin
            set_geometry($urandom_range(2, 4096), $urandom_range(2, 4096),
                         $urandom_range(1, 65535));
            push_random(100);
            wait_drained();
        end
        set_geometry($urandom_range(100, 2000), $urandom_range(100, 2000),
                     $urandom_range(20, 2000));
        push_random(100);
        wait_drained();

        if (n_errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        #4000000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

`default_nettype wire
